@@ sv/pulse_rate_detector_macros.svh @@
// Assertion macros used by the pulse rate detector back end.
`ifndef PULSE_RATE_DETECTOR_MACROS_SVH
`define PULSE_RATE_DETECTOR_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define PRD_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be true outside reset.
`define PRD_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PRD_ASSERT(name, clk, rst_n, prop, msg)
`define PRD_ASSERT_NEVER(name, clk, rst_n, cond, msg)
`endif

`endif

@@ sv/prd_pkg.sv @@
// Shared types and constants of the pulse rate detector.
package prd_pkg;

  localparam int TICK_W    = 32;
  localparam int THR_W     = 12;
  localparam int NUM_W     = 22;
  localparam int RATE_W    = 16;
  localparam int CFG_W     = 22;
  localparam int CFG_IDX_W = 2;

  // Levels are compared at this width so any sample width up to 16 bits fits.
  localparam int LVL_CMP_W = 16;

  // Depth of the beat queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BEAT_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_NUMERATOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_FLOOR     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_CEILING   = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [THR_W-1:0]  RST_BEAT_THRESHOLD = 12'd600;
  localparam logic [NUM_W-1:0]  RST_RATE_NUMERATOR = 22'd1200000;
  localparam logic [RATE_W-1:0] RST_RATE_FLOOR     = 16'd350;
  localparam logic [RATE_W-1:0] RST_RATE_CEILING   = 16'd1800;

  typedef struct packed {
    logic [THR_W-1:0]  beat_threshold;
    logic [NUM_W-1:0]  rate_numerator;
    logic [RATE_W-1:0] rate_floor;
    logic [RATE_W-1:0] rate_ceiling;
  } cfg_t;

endpackage

@@ sv/prd_front.sv @@
// Front end: trimmed level, crossing detection and beat interval capture.
module prd_front import prd_pkg::*; #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [SAMPLE_BITS-1:0] sample_a_i,
  input  logic [SAMPLE_BITS-1:0] sample_b_i,
  input  logic [SAMPLE_BITS-1:0] sample_c_i,
  input  logic [SAMPLE_BITS-1:0] sample_d_i,
  input  logic [TICK_W-1:0]      tick_now_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [THR_W-1:0]       beat_threshold_i,
  input  logic                   q_full_i,
  output logic                   q_push_o,
  output logic [TICK_W-1:0]      q_interval_o
);

  logic [SAMPLE_BITS-1:0] hi01, lo01, hi23, lo23, hi, lo;
  logic [SAMPLE_BITS+1:0] sum4;
  logic [SAMPLE_BITS+1:0] mid;
  logic [SAMPLE_BITS-1:0] level;
  logic                   accept;
  logic                   crossing;
  logic [TICK_W-1:0]      interval;

  logic                   primed_q, primed_d;
  logic [SAMPLE_BITS-1:0] prev_level_q, prev_level_d;
  logic [TICK_W-1:0]      last_tick_q, last_tick_d;

  // Drop the largest and smallest of the four samples, halve the sum of the other two.
  always_comb begin
    hi01 = (sample_a_i > sample_b_i) ? sample_a_i : sample_b_i;
    lo01 = (sample_a_i > sample_b_i) ? sample_b_i : sample_a_i;
    hi23 = (sample_c_i > sample_d_i) ? sample_c_i : sample_d_i;
    lo23 = (sample_c_i > sample_d_i) ? sample_d_i : sample_c_i;
    hi   = (hi01 > hi23) ? hi01 : hi23;
    lo   = (lo01 < lo23) ? lo01 : lo23;
    sum4 = (SAMPLE_BITS+2)'(sample_a_i) + (SAMPLE_BITS+2)'(sample_b_i)
         + (SAMPLE_BITS+2)'(sample_c_i) + (SAMPLE_BITS+2)'(sample_d_i);
    mid  = sum4 - (SAMPLE_BITS+2)'(hi) - (SAMPLE_BITS+2)'(lo);
    level = mid[SAMPLE_BITS:1];
  end

  // A rising crossing of the threshold marks a beat.
  assign crossing = (LVL_CMP_W'(prev_level_q) < LVL_CMP_W'(beat_threshold_i)) &&
                    (LVL_CMP_W'(level) >= LVL_CMP_W'(beat_threshold_i));
  assign interval = tick_now_i - last_tick_q;

  // Items stall only while the beat queue is full.
  assign in_ready_o   = !q_full_i;
  assign accept       = in_valid_i && in_ready_o;
  assign q_push_o     = accept && primed_q && crossing && (interval != '0);
  assign q_interval_o = interval;

  // The first item primes the level and beat time; crossings move the beat time.
  always_comb begin
    primed_d     = primed_q;
    prev_level_d = prev_level_q;
    last_tick_d  = last_tick_q;
    if (accept) begin
      primed_d     = 1'b1;
      prev_level_d = level;
      if (!primed_q || crossing) begin
        last_tick_d = tick_now_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q     <= 1'b0;
      prev_level_q <= '0;
      last_tick_q  <= '0;
    end else begin
      primed_q     <= primed_d;
      prev_level_q <= prev_level_d;
      last_tick_q  <= last_tick_d;
    end
  end

endmodule

@@ sv/prd_fifo.sv @@
// Short queue of beat intervals between the front and back ends.
module prd_fifo import prd_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             empty_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o     = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer wrap and occupancy count.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage, no reset needed.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ sv/prd_div.sv @@
// Restoring divider, one quotient bit per cycle.
module prd_div #(
  parameter int DVD_W = 22,
  parameter int DVS_W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   diff;
  logic             ge;

  // One trial subtraction of the shifted remainder.
  assign rem_sh = {rem_q, quo_q[DVD_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign ge     = (rem_sh >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo_d = {quo_q[DVD_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DVD_W - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

@@ sv/prd_back.sv @@
// Back end: beat rate division, rate window and trimmed-mean result.
`include "pulse_rate_detector_macros.svh"
module prd_back import prd_pkg::*; #(
  parameter int WINDOW_LEN = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              q_empty_i,
  input  logic [TICK_W-1:0] q_interval_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [RATE_W-1:0] smoothed_rate_o,
  output logic [RATE_W-1:0] latest_rate_o
);

  localparam int BEAT_W = $clog2(WINDOW_LEN + 1);
  localparam int SCAN_W = $clog2(WINDOW_LEN);
  localparam int SUM_W  = RATE_W + $clog2(WINDOW_LEN);

  // The trimmed sum is divided by WINDOW_LEN - 2 through a rounded-up reciprocal.
  // The extra three shift bits cover every divisor up to eight, so the floor is exact.
  localparam int MEAN_DIV = WINDOW_LEN - 2;
  localparam int MEAN_SH  = SUM_W + 3;
  localparam int MUL_W    = MEAN_SH + 1;
  localparam int PROD_W   = SUM_W + MUL_W;
  localparam logic [MUL_W-1:0] MEAN_MUL = MUL_W'((2**MEAN_SH + MEAN_DIV - 1) / MEAN_DIV);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DIV_RATE = 3'd1;
  localparam logic [2:0] ST_CHECK    = 3'd2;
  localparam logic [2:0] ST_SCAN     = 3'd3;
  localparam logic [2:0] ST_TRIM     = 3'd4;
  localparam logic [2:0] ST_EMIT     = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [RATE_W-1:0] window_q [WINDOW_LEN];
  logic [RATE_W-1:0] window_d [WINDOW_LEN];
  logic [BEAT_W-1:0] beats_q, beats_d;
  logic [SCAN_W-1:0] scan_q, scan_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [RATE_W-1:0] max_q, max_d, min_q, min_d;
  logic [RATE_W-1:0] rate_q, rate_d;
  logic [RATE_W-1:0] mean_q, mean_d;
  logic              out_vld_q, out_vld_d;
  logic [RATE_W-1:0] out_smooth_q, out_smooth_d;
  logic [RATE_W-1:0] out_latest_q, out_latest_d;

  logic              div_start;
  logic [NUM_W-1:0]  div_dividend;
  logic [TICK_W-1:0] div_divisor;
  logic              div_busy;
  logic [NUM_W-1:0]  div_quo;
  logic              in_range;
  logic              out_load;
  logic [SUM_W-1:0]  trimmed;
  logic [PROD_W-1:0] mean_prod;

  // Divider for the beat rate.
  prd_div #(
    .DVD_W (NUM_W),
    .DVS_W (TICK_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  assign in_range  = (div_quo > NUM_W'(cfg_i.rate_floor)) &&
                     (div_quo < NUM_W'(cfg_i.rate_ceiling));
  assign trimmed   = sum_q - SUM_W'(max_q) - SUM_W'(min_q);
  assign mean_prod = PROD_W'(trimmed) * PROD_W'(MEAN_MUL);

  // Sequencer for one beat.
  always_comb begin
    state_d      = state_q;
    window_d     = window_q;
    beats_d      = beats_q;
    scan_d       = scan_q;
    sum_d        = sum_q;
    max_d        = max_q;
    min_d        = min_q;
    rate_d       = rate_q;
    mean_d       = mean_q;
    q_pop_o      = 1'b0;
    div_start    = 1'b0;
    div_dividend = cfg_i.rate_numerator;
    div_divisor  = q_interval_i;
    out_load     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o   = 1'b1;
          div_start = 1'b1;
          state_d   = ST_DIV_RATE;
        end
      end
      ST_DIV_RATE: begin
        if (!div_busy) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_d = ST_IDLE;
        if (in_range) begin
          // Shift the new rate in at the top of the window.
          for (int i = 0; i < WINDOW_LEN - 1; i++) begin
            window_d[i] = window_q[i+1];
          end
          window_d[WINDOW_LEN-1] = div_quo[RATE_W-1:0];
          rate_d = div_quo[RATE_W-1:0];
          if (beats_q < BEAT_W'(WINDOW_LEN)) begin
            beats_d = beats_q + 1'b1;
          end else begin
            scan_d  = '0;
            sum_d   = '0;
            max_d   = '0;
            min_d   = '1;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // Visit one entry per cycle by rotating the window once around.
        sum_d = sum_q + SUM_W'(window_q[0]);
        if (window_q[0] > max_q) begin
          max_d = window_q[0];
        end
        if (window_q[0] < min_q) begin
          min_d = window_q[0];
        end
        for (int i = 0; i < WINDOW_LEN - 1; i++) begin
          window_d[i] = window_q[i+1];
        end
        window_d[WINDOW_LEN-1] = window_q[0];
        if (scan_q == SCAN_W'(WINDOW_LEN - 1)) begin
          state_d = ST_TRIM;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      ST_TRIM: begin
        mean_d  = mean_prod[MEAN_SH +: RATE_W];
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_vld_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register holds a result until it is taken.
  always_comb begin
    out_vld_d    = out_vld_q;
    out_smooth_d = out_smooth_q;
    out_latest_d = out_latest_q;
    if (out_load) begin
      out_vld_d    = 1'b1;
      out_smooth_d = mean_q;
      out_latest_d = rate_q;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      beats_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      beats_q   <= beats_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Window and working registers, no reset needed.
  always_ff @(posedge clk_i) begin
    window_q     <= window_d;
    scan_q       <= scan_d;
    sum_q        <= sum_d;
    max_q        <= max_d;
    min_q        <= min_d;
    rate_q       <= rate_d;
    mean_q       <= mean_d;
    out_smooth_q <= out_smooth_d;
    out_latest_q <= out_latest_d;
  end

  assign out_valid_o     = out_vld_q;
  assign smoothed_rate_o = out_smooth_q;
  assign latest_rate_o   = out_latest_q;

  // A result is only formed once the window is full.
  `PRD_ASSERT(a_result_window_full, clk_i, rst_ni, out_load |-> (beats_q == BEAT_W'(WINDOW_LEN)), "result with partial window")
  // The divider is never restarted while a division runs.
  `PRD_ASSERT(a_div_start_idle, clk_i, rst_ni, div_start |-> !div_busy, "divider restarted while busy")
  // The queue is never read while empty.
  `PRD_ASSERT_NEVER(a_pop_nonempty, clk_i, rst_ni, q_pop_o && q_empty_i, "pop from empty beat queue")

endmodule

@@ sv/pulse_rate_detector.sv @@
// Each item is taken while the two-entry beat queue has room; only beats reach the back end.
// Each beat passes through the back end as pop, 22-step rate division and range check; a beat that
// yields a result also passes through window scan, trim and output load. Results wait in an output
// register until transferred. Reset (asynchronous, active low) clears the level history, beat count
// and queue, and loads the configuration registers with their defaults.
module pulse_rate_detector import prd_pkg::*; #(
  parameter int WINDOW_LEN  = 5,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] sample_a_i,
  input  logic [SAMPLE_BITS-1:0] sample_b_i,
  input  logic [SAMPLE_BITS-1:0] sample_c_i,
  input  logic [SAMPLE_BITS-1:0] sample_d_i,
  input  logic [TICK_W-1:0]      tick_now_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [RATE_W-1:0]      smoothed_rate_o,
  output logic [RATE_W-1:0]      latest_rate_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i
);

  cfg_t              cfg_q, cfg_d;
  logic              q_push, q_full, q_pop, q_empty;
  logic [TICK_W-1:0] q_push_data, q_pop_data;

  // Configuration register writes.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BEAT_THRESHOLD: cfg_d.beat_threshold = cfg_wdata_i[THR_W-1:0];
        CFG_RATE_NUMERATOR: cfg_d.rate_numerator = cfg_wdata_i[NUM_W-1:0];
        CFG_RATE_FLOOR:     cfg_d.rate_floor     = cfg_wdata_i[RATE_W-1:0];
        CFG_RATE_CEILING:   cfg_d.rate_ceiling   = cfg_wdata_i[RATE_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.beat_threshold <= RST_BEAT_THRESHOLD;
      cfg_q.rate_numerator <= RST_RATE_NUMERATOR;
      cfg_q.rate_floor     <= RST_RATE_FLOOR;
      cfg_q.rate_ceiling   <= RST_RATE_CEILING;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front end classifies each item and queues beat intervals.
  prd_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .sample_a_i       (sample_a_i),
    .sample_b_i       (sample_b_i),
    .sample_c_i       (sample_c_i),
    .sample_d_i       (sample_d_i),
    .tick_now_i       (tick_now_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .beat_threshold_i (cfg_q.beat_threshold),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .q_interval_o     (q_push_data)
  );

  prd_fifo #(
    .WIDTH (TICK_W)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_pop_data),
    .empty_o     (q_empty)
  );

  // Back end turns intervals into rates and results.
  prd_back #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .q_empty_i       (q_empty),
    .q_interval_i    (q_pop_data),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .smoothed_rate_o (smoothed_rate_o),
    .latest_rate_o   (latest_rate_o)
  );

endmodule
